/* rtl/core/asbf_pkg.sv */
`default_nettype none

package asbf_pkg;

    // Number of big-endian bytes that make up an attachment length.
    localparam int unsigned LEN_BYTES = 4;
    localparam int unsigned LEN_IDX_W = $clog2(LEN_BYTES);

    // Largest value that the zero counter can hold.
    localparam logic [3:0] ZERO_COUNT_MAX = 4'd15;

    // Value of the threshold register after reset.
    localparam logic [3:0] ZERO_THRESHOLD_RESET = 4'd8;

    // Largest value of the kept-byte total.
    localparam logic [31:0] KEPT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        MODE_TEXT = 4'b0001,
        MODE_NAME = 4'b0010,
        MODE_LEN  = 4'b0100,
        MODE_SKIP = 4'b1000
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } asbf_req_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        end_flag;
        logic [31:0] kept_count;
    } asbf_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/attachment_stripping_byte_filter_unit.sv */
// A request that yields a result has it registered in the output queue, whose head slot drives the output.
// Throughput: one request per cycle while the output queue has room; the parse state is updated once per byte.
// A two-entry output queue lets requests keep flowing while a result waits to be taken.
// Reset (rst_n, asynchronous, active low) returns the parser to text mode, clears the
// counters, empties the output queue and sets the zero threshold to eight.
`default_nettype none

module attachment_stripping_byte_filter_unit
    import asbf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,

    input  wire logic      cfg_we,
    input  wire logic [3:0] cfg_wdata,

    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire asbf_req_t req_data,

    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output asbf_rsp_t      rsp_data
);

    // Configuration register: how many zero bytes in text announce an attachment.
    // A value of zero switches attachment detection off.
    logic [3:0] threshold_reg;

    // Parser state.
    parse_mode_t          mode_reg, mode_next;
    logic [3:0]           zero_count_reg, zero_count_next;
    logic [LEN_IDX_W-1:0] len_idx_reg, len_idx_next;
    logic [31:0]          skip_reg, skip_next;
    logic [31:0]          kept_reg, kept_next;

    // Output queue: slot0 is the head and is what the consumer sees.
    logic [1:0] count_reg, count_next;
    asbf_rsp_t  slot0_reg, slot0_next;
    asbf_rsp_t  slot1_reg, slot1_next;

    logic       req_accept;
    logic       rsp_pop;
    logic       rsp_push;
    logic       keep;
    asbf_rsp_t  rsp_new;

    logic [4:0]  zero_inc;
    logic [31:0] len_shifted;
    logic [31:0] skip_dec;

    // A request is always taken while the queue has room for its possible result.
    assign req_ready  = (count_reg != 2'd2);
    assign req_accept = req_valid && req_ready;
    assign rsp_valid  = (count_reg != 2'd0);
    assign rsp_pop    = rsp_valid && rsp_ready;
    assign rsp_data   = slot0_reg;

    assign zero_inc    = {1'b0, zero_count_reg} + 5'd1;
    assign len_shifted = {skip_reg[23:0], req_data.data_byte};
    assign skip_dec    = skip_reg - 32'd1;

    // Per-byte parse step. Only a text byte that is not zero is kept; the name,
    // the length field and the payload of an attachment are all dropped.
    always_comb
    begin
        mode_next       = mode_reg;
        zero_count_next = zero_count_reg;
        len_idx_next    = len_idx_reg;
        skip_next       = skip_reg;
        kept_next       = kept_reg;
        keep            = 1'b0;

        if (req_accept)
        begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    if (req_data.data_byte != 8'd0)
                    begin
                        keep = 1'b1;
                        if (kept_reg != KEPT_MAX)
                        begin
                            kept_next = kept_reg + 32'd1;
                        end
                    end
                    else if ((threshold_reg != 4'd0) && (zero_inc >= {1'b0, threshold_reg}))
                    begin
                        // Zeros are counted over the whole text, not only in runs.
                        zero_count_next = 4'd0;
                        mode_next       = MODE_NAME;
                    end
                    else if (zero_inc > {1'b0, ZERO_COUNT_MAX})
                    begin
                        zero_count_next = ZERO_COUNT_MAX;
                    end
                    else
                    begin
                        zero_count_next = zero_inc[3:0];
                    end
                end
                MODE_NAME:
                begin
                    // The name ends at its terminating zero, which may come at once.
                    if (req_data.data_byte == 8'd0)
                    begin
                        mode_next    = MODE_LEN;
                        len_idx_next = '0;
                        skip_next    = 32'd0;
                    end
                end
                MODE_LEN:
                begin
                    skip_next    = len_shifted;
                    len_idx_next = len_idx_reg + LEN_IDX_W'(1);
                    if (len_idx_reg == LEN_IDX_W'(LEN_BYTES - 1))
                    begin
                        // A zero length returns straight to text.
                        mode_next = (len_shifted == 32'd0) ? MODE_TEXT : MODE_SKIP;
                    end
                end
                MODE_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0)
                    begin
                        mode_next = MODE_TEXT;
                    end
                end
                default:
                begin
                    mode_next = MODE_TEXT;
                end
            endcase
        end

        rsp_new.out_byte   = keep ? req_data.data_byte : 8'd0;
        rsp_new.out_valid  = keep;
        rsp_new.end_flag   = req_data.end_of_file;
        rsp_new.kept_count = req_data.end_of_file ? kept_next : 32'd0;

        // End of file closes the message, even inside a truncated attachment,
        // and the next byte starts a fresh one.
        if (req_accept && req_data.end_of_file)
        begin
            mode_next       = MODE_TEXT;
            zero_count_next = 4'd0;
            len_idx_next    = '0;
            skip_next       = 32'd0;
            kept_next       = 32'd0;
        end
    end

    assign rsp_push = req_accept && (keep || req_data.end_of_file);

    // Output queue bookkeeping.
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;

        if (rsp_push && rsp_pop)
        begin
            if (count_reg == 2'd2)
            begin
                slot0_next = slot1_reg;
                slot1_next = rsp_new;
            end
            else
            begin
                slot0_next = rsp_new;
            end
        end
        else if (rsp_pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (rsp_push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_next = rsp_new;
            end
            else
            begin
                slot1_next = rsp_new;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= ZERO_THRESHOLD_RESET;
            mode_reg       <= MODE_TEXT;
            zero_count_reg <= 4'd0;
            len_idx_reg    <= '0;
            skip_reg       <= 32'd0;
            kept_reg       <= 32'd0;
            count_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            mode_reg       <= mode_next;
            zero_count_reg <= zero_count_next;
            len_idx_reg    <= len_idx_next;
            skip_reg       <= skip_next;
            kept_reg       <= kept_next;
            count_reg      <= count_next;
        end
    end

    // Queue payload needs no reset; count_reg says which slots hold results.
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`ifndef NO_ASSERTIONS
    // While skipping payload there is always at least one byte left to drop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SKIP) |-> (skip_reg != 32'd0))
        else $error("payload skip entered with nothing to drop");

    // After the final byte of a file the parser is back in text with no bytes counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req_data.end_of_file) |=>
            ((mode_reg == MODE_TEXT) && (kept_reg == 32'd0) && (zero_count_reg == 4'd0)))
        else $error("state not cleared after end of file");

    // Within a file the kept total never goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && !req_data.end_of_file) |=> (kept_reg >= $past(kept_reg)))
        else $error("kept total decreased within a file");

    // A result pushed into an empty queue is offered as soon as it is registered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_push && (count_reg == 2'd0)) |=> rsp_valid)
        else $error("result lost from output queue");
`endif

endmodule

`default_nettype wire
